FILE: hdl/ogbm_pkg.sv
// ----------------------------------------------------------------------------
// ogbm_pkg
// Shared types and constants of the overlap group box merge block.
// ----------------------------------------------------------------------------
package ogbm_pkg;

	localparam int IN_BITS  = 16;  // request coordinate width, two's complement
	localparam int OUT_BITS = 12;  // result coordinate width
	localparam int DIM_BITS = 13;  // image size register width

	// register indexes (byte address bit 2)
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 13'd640;
	localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 13'd480;

	// coordinate slots inside a stored box
	localparam int C_LEFT   = 0;
	localparam int C_TOP    = 1;
	localparam int C_RIGHT  = 2;
	localparam int C_BOTTOM = 3;

	typedef struct packed {
		logic signed [IN_BITS-1:0] left_edge;
		logic signed [IN_BITS-1:0] top_edge;
		logic signed [IN_BITS-1:0] right_edge;
		logic signed [IN_BITS-1:0] bottom_edge;
		logic                      final_box;
	} box_req_t;

	typedef struct packed {
		logic [OUT_BITS-1:0] merged_left;
		logic [OUT_BITS-1:0] merged_top;
		logic [OUT_BITS-1:0] merged_right;
		logic [OUT_BITS-1:0] merged_bottom;
		logic                last_group;
		logic                boxes_dropped;
	} merge_res_t;

endpackage

FILE: hdl/overlap_group_box_merge.sv
// ----------------------------------------------------------------------------
// overlap_group_box_merge
// Stores clamped detection boxes, then after the final box of a frame
// groups overlapping boxes into connected sets and emits one enclosing
// rectangle per set, in order of each set's lowest-indexed box.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                          Payload
// request   in         start & !busy                      box (box_req_t)
// result    out        result_strobe, one cycle, no stall result (merge_res_t)
// config    in         APB write: psel & penable & pwrite image_width @0x0,
//                                                         image_height @0x4
//
// A box that is not final is stored (dropped and flagged if the store is
// full); busy stays low. The final box starts the grouping pass, busy high
// throughout. A root scan step reads store and marks, then checks the root;
// a box taken from the work queue is popped, read and latched, then gets one
// compare per index after the root, all through the single overlap compare
// unit and the box store read port. A flush state emits the last rectangle.
// Reset: clears box count, overflow flag and sequencer; no clearing pass,
// visited marks are cleared as each box is written into the store.
// Results leave on consecutive or spaced cycles; the receiver cannot stall.
// ----------------------------------------------------------------------------
module overlap_group_box_merge #(
	parameter int MAX_BOXES  = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// request
	input  logic                   start,
	output logic                   busy,
	input  ogbm_pkg::box_req_t     box,
	// result
	output logic                   result_strobe,
	output ogbm_pkg::merge_res_t   result,
	// configuration
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);
	import ogbm_pkg::*;

	localparam int COORD_BITS = OUT_BITS;           // stored coordinate width
	localparam int IW = $clog2(MAX_BOXES);      // store index
	localparam int CW = $clog2(MAX_BOXES + 1);  // count, can hold MAX_BOXES
	localparam int BW = 4 * COORD_BITS;         // one stored box

	// sequencer states
	localparam logic [3:0] S_LOAD     = 4'd0;  // idle, taking boxes
	localparam logic [3:0] S_ROOT_RD  = 4'd1;  // read store/marks at root index
	localparam logic [3:0] S_ROOT_CHK = 4'd2;  // new group if root not visited
	localparam logic [3:0] S_POP      = 4'd3;  // read work queue head
	localparam logic [3:0] S_CUR_RD   = 4'd4;  // read store at popped index
	localparam logic [3:0] S_CUR_LD   = 4'd5;  // latch current box, start sweep
	localparam logic [3:0] S_SWEEP    = 4'd6;  // one compare per index after the root
	localparam logic [3:0] S_NEXT     = 4'd7;  // more work, or group done
	localparam logic [3:0] S_FLUSH    = 4'd8;  // emit last rectangle

	logic [3:0] state_q;

	// configuration
	logic [DIM_BITS-1:0] width_q, height_q;
	logic                cfg_wr;

	// control
	logic [CW-1:0] count_q, i_q, j_q, head_q, tail_q;
	logic          overflow_q, pend_vld_q;

	// payload
	logic [3:0][COORD_BITS-1:0] ext_q, pend_q, cur_q;
	logic [3:0][COORD_BITS-1:0] clamped, grown, box_rd;
	merge_res_t                 res_d;

	// memory ports
	logic          box_we, vis_we, vis_wdata, vis_rdata, q_we;
	logic [IW-1:0] box_waddr, box_raddr, vis_waddr, vis_raddr, q_waddr, q_raddr;
	logic [IW-1:0] q_wdata, q_rdata;
	logic [BW-1:0] box_rdata;

	logic accept, link, hit, res_load, res_last;
	logic [CW-1:0] i_nx, j_nx;

	assign accept = start && !busy;
	assign busy   = (state_q != S_LOAD);
	assign box_rd = box_rdata;
	assign i_nx   = i_q + CW'(1);
	assign j_nx   = j_q + CW'(1);
	assign hit    = (state_q == S_SWEEP) && link && !vis_rdata;

	// ---------------------------------------------------------------- config
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[2])
			REG_IMAGE_WIDTH:  prdata = 32'(width_q);
			REG_IMAGE_HEIGHT: prdata = 32'(height_q);
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_IMAGE_WIDTH:  width_q  <= pwdata[DIM_BITS-1:0];
				REG_IMAGE_HEIGHT: height_q <= pwdata[DIM_BITS-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------- datapath units
	ogbm_clamp #(.COORD_BITS(COORD_BITS)) u_clamp (
		.req          (box),
		.image_width  (width_q),
		.image_height (height_q),
		.box          (clamped)
	);

	// the one overlap compare, shared by every pair of the pass
	ogbm_link #(.COORD_BITS(COORD_BITS)) u_link (
		.box_a (cur_q),
		.box_b (box_rd),
		.link  (link)
	);

	always_comb begin
		grown[C_LEFT]   = (box_rd[C_LEFT] < ext_q[C_LEFT]) ? box_rd[C_LEFT] : ext_q[C_LEFT];
		grown[C_TOP]    = (box_rd[C_TOP] < ext_q[C_TOP]) ? box_rd[C_TOP] : ext_q[C_TOP];
		grown[C_RIGHT]  = (box_rd[C_RIGHT] > ext_q[C_RIGHT]) ? box_rd[C_RIGHT]
		                                                     : ext_q[C_RIGHT];
		grown[C_BOTTOM] = (box_rd[C_BOTTOM] > ext_q[C_BOTTOM]) ? box_rd[C_BOTTOM]
		                                                       : ext_q[C_BOTTOM];
	end

	// -------------------------------------------------------------- memories
	// read addresses are issued in the state before the one using the data
	always_comb begin
		case (state_q)
			S_CUR_RD: box_raddr = q_rdata;
			S_CUR_LD: box_raddr = i_nx[IW-1:0];
			S_SWEEP:  box_raddr = j_nx[IW-1:0];
			default:  box_raddr = i_q[IW-1:0];
		endcase
		vis_raddr = box_raddr;
		q_raddr   = head_q[IW-1:0];
	end

	always_comb begin
		box_we    = accept && (count_q < CW'(MAX_BOXES));
		box_waddr = count_q[IW-1:0];
		vis_we    = 1'b0;
		vis_waddr = count_q[IW-1:0];
		vis_wdata = 1'b0;  // mark cleared as the box is stored
		q_we      = 1'b0;
		q_waddr   = tail_q[IW-1:0];
		q_wdata   = j_q[IW-1:0];
		case (state_q)
			S_LOAD: begin
				vis_we = box_we;
			end
			S_ROOT_CHK: begin
				vis_we    = !vis_rdata;
				vis_waddr = i_q[IW-1:0];
				vis_wdata = 1'b1;
				q_we      = !vis_rdata;
				q_waddr   = '0;
				q_wdata   = i_q[IW-1:0];
			end
			S_SWEEP: begin
				vis_we    = hit;
				vis_waddr = j_q[IW-1:0];
				vis_wdata = 1'b1;
				q_we      = hit;
			end
			default: ;
		endcase
	end

	ogbm_ram #(.WIDTH(BW), .DEPTH(MAX_BOXES)) u_box_store (
		.clk   (clk),
		.we    (box_we),
		.waddr (box_waddr),
		.wdata (clamped),
		.raddr (box_raddr),
		.rdata (box_rdata)
	);

	ogbm_ram #(.WIDTH(1), .DEPTH(MAX_BOXES)) u_visited (
		.clk   (clk),
		.we    (vis_we),
		.waddr (vis_waddr),
		.wdata (vis_wdata),
		.raddr (vis_raddr),
		.rdata (vis_rdata)
	);

	ogbm_ram #(.WIDTH(IW), .DEPTH(MAX_BOXES)) u_queue (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.raddr (q_raddr),
		.rdata (q_rdata)
	);

	// ------------------------------------------------------------- sequencer
	// a finished group waits in pend_q until the next one closes or the flush, so the
	// last rectangle of the frame can carry last_group
	assign res_load = ((state_q == S_NEXT) && (head_q == tail_q) && pend_vld_q)
	                  || (state_q == S_FLUSH);
	assign res_last = (state_q == S_FLUSH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_LOAD;
			count_q       <= '0;
			overflow_q    <= 1'b0;
			pend_vld_q    <= 1'b0;
			i_q           <= '0;
			j_q           <= '0;
			head_q        <= '0;
			tail_q        <= '0;
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= res_load;
			unique case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (box_we) begin
							count_q <= count_q + CW'(1);
						end else begin
							overflow_q <= 1'b1;
						end
						if (box.final_box) begin
							i_q     <= '0;
							state_q <= S_ROOT_RD;
						end
					end
				end
				S_ROOT_RD: begin
					state_q <= S_ROOT_CHK;
				end
				S_ROOT_CHK: begin
					if (!vis_rdata) begin
						head_q  <= '0;
						tail_q  <= CW'(1);
						state_q <= S_POP;
					end else begin
						i_q     <= i_nx;
						state_q <= (i_nx == count_q) ? S_FLUSH : S_ROOT_RD;
					end
				end
				S_POP: begin
					head_q  <= head_q + CW'(1);
					state_q <= S_CUR_RD;
				end
				S_CUR_RD: begin
					state_q <= S_CUR_LD;
				end
				S_CUR_LD: begin
					j_q     <= i_nx;
					state_q <= (i_nx < count_q) ? S_SWEEP : S_NEXT;
				end
				S_SWEEP: begin
					if (hit) begin
						tail_q <= tail_q + CW'(1);
					end
					j_q     <= j_nx;
					state_q <= (j_nx < count_q) ? S_SWEEP : S_NEXT;
				end
				S_NEXT: begin
					if (head_q != tail_q) begin
						state_q <= S_POP;
					end else begin
						pend_vld_q <= 1'b1;
						i_q        <= i_nx;
						state_q    <= (i_nx == count_q) ? S_FLUSH : S_ROOT_RD;
					end
				end
				S_FLUSH: begin
					count_q    <= '0;
					overflow_q <= 1'b0;
					pend_vld_q <= 1'b0;
					state_q    <= S_LOAD;
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// --------------------------------------------------------- payload regs
	always_comb begin
		res_d.merged_left   = OUT_BITS'(pend_q[C_LEFT]);
		res_d.merged_top    = OUT_BITS'(pend_q[C_TOP]);
		res_d.merged_right  = OUT_BITS'(pend_q[C_RIGHT]);
		res_d.merged_bottom = OUT_BITS'(pend_q[C_BOTTOM]);
		res_d.last_group    = res_last;
		res_d.boxes_dropped = overflow_q;
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_ROOT_CHK) && !vis_rdata) begin
			ext_q <= box_rd;
		end else if (hit) begin
			ext_q <= grown;
		end
		if (state_q == S_CUR_LD) begin
			cur_q <= box_rd;
		end
		if ((state_q == S_NEXT) && (head_q == tail_q)) begin
			pend_q <= ext_q;
		end
		if (res_load) begin
			result <= res_d;
		end
	end

endmodule

FILE: hdl/ogbm_ram.sv
// ----------------------------------------------------------------------------
// ogbm_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module ogbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hdl/ogbm_clamp.sv
// ----------------------------------------------------------------------------
// ogbm_clamp
// Saturates the four request coordinates into the image.
// ----------------------------------------------------------------------------
module ogbm_clamp #(
	parameter int COORD_BITS = 12
) (
	input  ogbm_pkg::box_req_t                    req,
	input  logic [ogbm_pkg::DIM_BITS-1:0]         image_width,
	input  logic [ogbm_pkg::DIM_BITS-1:0]         image_height,
	output logic [3:0][COORD_BITS-1:0]            box
);
	import ogbm_pkg::*;

	// wide enough for 2^COORD_BITS, any register value and a positive coord
	localparam int CMP_BITS = IN_BITS + 1;
	localparam logic [CMP_BITS-1:0] LIMIT = CMP_BITS'(1) << COORD_BITS;

	logic [CMP_BITS-1:0]        w_eff, h_eff;
	logic [COORD_BITS-1:0]      w_hi, h_hi;
	logic signed [IN_BITS-1:0]  coord [4];

	always_comb begin
		w_eff = CMP_BITS'(image_width);
		if (w_eff == '0) begin
			w_eff = CMP_BITS'(1);
		end else if (w_eff > LIMIT) begin
			w_eff = LIMIT;
		end
		h_eff = CMP_BITS'(image_height);
		if (h_eff == '0) begin
			h_eff = CMP_BITS'(1);
		end else if (h_eff > LIMIT) begin
			h_eff = LIMIT;
		end
		w_hi = COORD_BITS'(w_eff - CMP_BITS'(1));
		h_hi = COORD_BITS'(h_eff - CMP_BITS'(1));
	end

	assign coord[C_LEFT]   = req.left_edge;
	assign coord[C_TOP]    = req.top_edge;
	assign coord[C_RIGHT]  = req.right_edge;
	assign coord[C_BOTTOM] = req.bottom_edge;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			logic [COORD_BITS-1:0] hi;
			hi = ((k == C_LEFT) || (k == C_RIGHT)) ? w_hi : h_hi;
			if (coord[k] < 0) begin
				box[k] = '0;
			end else if (CMP_BITS'(unsigned'(coord[k])) > CMP_BITS'(hi)) begin
				box[k] = hi;
			end else begin
				box[k] = COORD_BITS'(unsigned'(coord[k]));
			end
		end
	end

endmodule

FILE: hdl/ogbm_link.sv
// ----------------------------------------------------------------------------
// ogbm_link
// Overlap compare: two boxes link when their intersection is strictly
// positive in both width and height.
// ----------------------------------------------------------------------------
module ogbm_link #(
	parameter int COORD_BITS = 12
) (
	input  logic [3:0][COORD_BITS-1:0] box_a,
	input  logic [3:0][COORD_BITS-1:0] box_b,
	output logic                       link
);
	import ogbm_pkg::*;

	logic [COORD_BITS-1:0] il, it, ir, ib;

	always_comb begin
		il = (box_a[C_LEFT]   > box_b[C_LEFT])   ? box_a[C_LEFT]   : box_b[C_LEFT];
		it = (box_a[C_TOP]    > box_b[C_TOP])    ? box_a[C_TOP]    : box_b[C_TOP];
		ir = (box_a[C_RIGHT]  < box_b[C_RIGHT])  ? box_a[C_RIGHT]  : box_b[C_RIGHT];
		ib = (box_a[C_BOTTOM] < box_b[C_BOTTOM]) ? box_a[C_BOTTOM] : box_b[C_BOTTOM];
		link = (ir > il) && (ib > it);
	end

endmodule
